/* src/skf_pkg.sv */
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter bank
// Holds the sequencer states, the divider request and response, the
// fixed-point constants and the filter index reduction.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int INDEX_BITS = 8;
  localparam int ROW_BITS   = 12;
  localparam int NOISE_BITS = 16;
  localparam int COV_BITS   = 32;
  localparam int CFG_IDX_W  = 8;

  localparam int DIV_W     = 33;
  localparam int Q_W       = 17;
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 8'd1;

  localparam logic [NOISE_BITS-1:0] PROCESS_NOISE_RESET     = 16'd512;
  localparam logic [NOISE_BITS-1:0] MEASUREMENT_NOISE_RESET = 16'd768;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  localparam logic [COV_BITS-1:0] P_INIT      = 32'd65536;
  localparam logic [MUL_B_W-1:0]  PNOISE_BIAS = 32'd1311;
  localparam logic [MUL_B_W-1:0]  RNOISE_ONE  = 32'd65536;
  localparam logic [Q_W-1:0]      K_ONE       = 17'd65536;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FAR_DIV,
    ST_FAR2,
    ST_FAR3,
    ST_QF,
    ST_RF,
    ST_DEN,
    ST_K_START,
    ST_K_DIV,
    ST_X_MUL,
    ST_P_MUL,
    ST_WRITE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num_hi;
    logic             num_lo;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quotient;
  } div_rsp_t;

  // Remainder of an 8-bit index by the bank size, one bit per step.
  function automatic logic [INDEX_BITS-1:0] idx_mod(input logic [INDEX_BITS-1:0] value,
                                                    input logic [10:0] modulus);
    logic [10:0] rem;
    rem = '0;
    for (int i = INDEX_BITS - 1; i >= 0; i--) begin
      rem = {rem[9:0], value[i]};
      if (rem >= modulus) begin
        rem = rem - modulus;
      end
    end
    return rem[INDEX_BITS-1:0];
  endfunction

endpackage

/* src/skf_div.sv */
// ----------------------------------------------------------------------------
// skf_div: iterative restoring divider
// Produces a 17-bit quotient, one bit per cycle, for a dividend whose upper
// part is already below the divisor.
// ----------------------------------------------------------------------------
module skf_div (
  input  logic              clk,
  input  logic              rst,
  input  skf_pkg::div_req_t req,
  output skf_pkg::div_rsp_t rsp
);
  import skf_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     divisor;
  logic                 next_bit;
  logic [Q_W-1:0]       quotient;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic [DIV_W:0]       trial;
  logic                 ge;

  assign trial = {rem, next_bit};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= req.num_hi;
      next_bit <= req.num_lo;
      divisor  <= req.divisor;
      quotient <= '0;
    end else if (cnt != '0) begin
      rem      <= ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      next_bit <= 1'b0;
      quotient <= {quotient[Q_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quotient;

endmodule

/* src/skf_store.sv */
// ----------------------------------------------------------------------------
// skf_store: per-filter state memories
// One memory holds the seen flag with the estimate, a second the covariance.
// Both are read at one address with registered read data.
// ----------------------------------------------------------------------------
module skf_store #(
  parameter  int DEPTH = 256,
  parameter  int EST_W = 20,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic                         rd_seen,
  output logic [EST_W-1:0]             rd_est,
  output logic [skf_pkg::COV_BITS-1:0] rd_cov,
  input  logic [AW-1:0]                wr_addr,
  input  logic                         est_we,
  input  logic                         wr_seen,
  input  logic [EST_W-1:0]             wr_est,
  input  logic                         cov_we,
  input  logic [skf_pkg::COV_BITS-1:0] wr_cov
);
  import skf_pkg::*;

  logic [EST_W:0]        est_mem [DEPTH];
  logic [COV_BITS-1:0]   cov_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (est_we) begin
      est_mem[wr_addr] <= {wr_seen, wr_est};
    end
    if (rd_en) begin
      {rd_seen, rd_est} <= est_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cov_we) begin
      cov_mem[wr_addr] <= wr_cov;
    end
    if (rd_en) begin
      rd_cov <= cov_mem[rd_addr];
    end
  end

endmodule

/* src/scalar_kalman_filter_bank.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_filter_bank: bank of one-dimensional Kalman filters
// Tracks one column estimate per filter with distance-scaled noise.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis; tuser carries the action (update or clear).
// An update item returns one result item on m_axis: the Q12.8 estimate and
// its rounded column in tdata, and in tuser a flag that marks the item that
// initialized the filter. A clear item returns nothing.
// Noise registers are written on the cfg channel, which is always ready.
// The block works on one item at a time. An update of a seen filter puts its
// result out after two 17-step passes of the shared divider plus a chain of
// steps on one shared 17x32 multiplier, and then takes the next item. A
// filter's first item skips the divider and the multiplier and puts its result
// out straight after the check.
// After reset, and after each clear item, the seen flags of all filters are
// swept and no item is accepted during the sweep; config writes are still
// taken. The result waits in an output register, so the next item is accepted
// while it is stalled; a further result waits until it is taken.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_bank #(
  parameter  int FILTER_COUNT = 256,
  parameter  int COORD_BITS   = 12,
  localparam int IN_BITS      = skf_pkg::INDEX_BITS + COORD_BITS + 2 * skf_pkg::ROW_BITS,
  localparam int IN_W         = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS     = 2 * COORD_BITS + 8,
  localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // filter_index, measured_column, row_offset, row_span
  input  logic [IN_W-1:0]               s_axis_tdata,
  // action
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // filtered_position, rounded_column
  output logic [OUT_W-1:0]              m_axis_tdata,
  // first_sample
  output logic                          m_axis_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import skf_pkg::*;

  localparam int AW    = $clog2(FILTER_COUNT);
  localparam int EST_W = COORD_BITS + 8;
  localparam int M_LO  = INDEX_BITS;
  localparam int O_LO  = M_LO + COORD_BITS;
  localparam int S_LO  = O_LO + ROW_BITS;

  state_t state, state_next;

  logic [AW-1:0]         clr_cnt;
  logic [NOISE_BITS-1:0] pn, mn;

  logic [AW-1:0]         idx;
  logic [EST_W-1:0]      meas;
  logic [ROW_BITS-1:0]   off, span;
  logic [Q_W-1:0]        far, far2, far3, k;
  logic [EST_W-1:0]      x, xn;
  logic [COV_BITS-1:0]   cov, p;
  logic [DIV_W-1:0]      denom;
  logic                  first;
  logic [PROD_W-1:0]     prod;

  logic                  out_valid;
  logic [EST_W-1:0]      out_pos;
  logic [COORD_BITS-1:0] out_col;
  logic                  out_first;

  logic                  accept, out_free, out_load;
  logic [AW-1:0]         idx_in;
  logic [ROW_BITS-1:0]   fdiff;
  logic                  far_zero;
  logic                  x_ge;
  logic [EST_W-1:0]      x_diff, x_step;
  logic [COV_BITS:0]     p_sum;
  logic [EST_W:0]        rsum;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;

  logic                  rd_seen;
  logic [EST_W-1:0]      rd_est;
  logic [COV_BITS-1:0]   rd_cov;
  logic [AW-1:0]         wr_addr;
  logic                  est_we, cov_we, wr_seen;
  logic [EST_W-1:0]      wr_est;
  logic [COV_BITS-1:0]   wr_cov;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign idx_in   = AW'(idx_mod(s_axis_tdata[INDEX_BITS-1:0], 11'(FILTER_COUNT)));
  assign fdiff    = span - off;
  assign far_zero = off >= span;
  assign x_ge     = meas >= x;
  assign x_diff   = x_ge ? meas - x : x - meas;
  assign x_step   = prod[16 +: EST_W];
  assign p_sum    = {1'b0, cov} + (COV_BITS + 1)'(prod[35:8]);
  assign rsum     = {1'b0, xn} + (EST_W + 1)'(128);

  skf_store #(
    .DEPTH (FILTER_COUNT),
    .EST_W (EST_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (idx_in),
    .rd_seen (rd_seen),
    .rd_est  (rd_est),
    .rd_cov  (rd_cov),
    .wr_addr (wr_addr),
    .est_we  (est_we),
    .wr_seen (wr_seen),
    .wr_est  (wr_est),
    .cov_we  (cov_we),
    .wr_cov  (wr_cov)
  );

  skf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(FILTER_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser == ACT_CLEAR) ? ST_CLEAR : ST_CHECK;
        end
      end
      ST_CHECK:   state_next = rd_seen ? ST_FAR_DIV : ST_EMIT;
      ST_FAR_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_FAR2;
        end
      end
      ST_FAR2:    state_next = ST_FAR3;
      ST_FAR3:    state_next = ST_QF;
      ST_QF:      state_next = ST_RF;
      ST_RF:      state_next = ST_DEN;
      ST_DEN:     state_next = ST_K_START;
      ST_K_START: state_next = ST_K_DIV;
      ST_K_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_X_MUL;
        end
      end
      ST_X_MUL:   state_next = ST_P_MUL;
      ST_P_MUL:   state_next = ST_WRITE;
      ST_WRITE:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    div_req       = '0;
    mul_a         = '0;
    mul_b         = '0;
    wr_addr       = idx;
    est_we        = 1'b0;
    cov_we        = 1'b0;
    wr_seen       = 1'b1;
    wr_est        = xn;
    wr_cov        = prod[47:16];
    unique case (state)
      ST_CLEAR: begin
        wr_addr = clr_cnt;
        est_we  = 1'b1;
        wr_seen = 1'b0;
        wr_est  = '0;
      end
      ST_IDLE: s_axis_tready = 1'b1;
      ST_CHECK: begin
        if (rd_seen) begin
          div_req.start   = 1'b1;
          div_req.num_hi  = DIV_W'(fdiff[ROW_BITS-1:1]);
          div_req.num_lo  = fdiff[0];
          div_req.divisor = DIV_W'(span);
        end else begin
          est_we = 1'b1;
          cov_we = 1'b1;
          wr_est = meas;
          wr_cov = P_INIT;
        end
      end
      ST_FAR2: begin
        mul_a = far;
        mul_b = MUL_B_W'(far);
      end
      ST_FAR3: begin
        mul_a = far;
        mul_b = MUL_B_W'(prod[32:16]);
      end
      ST_QF: begin
        mul_a = MUL_A_W'(pn);
        mul_b = PNOISE_BIAS + MUL_B_W'({far2, 3'b0});
      end
      ST_RF: begin
        mul_a = MUL_A_W'(mn);
        mul_b = RNOISE_ONE + MUL_B_W'({far3, 5'b0}) + MUL_B_W'({far3, 4'b0})
              + MUL_B_W'({far3, 1'b0});
      end
      ST_K_START: begin
        div_req.start   = 1'b1;
        div_req.num_hi  = DIV_W'(p[COV_BITS-1:1]);
        div_req.num_lo  = p[0];
        div_req.divisor = denom;
      end
      ST_X_MUL: begin
        mul_a = k;
        mul_b = MUL_B_W'(x_diff);
      end
      ST_P_MUL: begin
        mul_a = K_ONE - k;
        mul_b = p;
      end
      ST_WRITE: begin
        est_we = 1'b1;
        cov_we = 1'b1;
      end
      ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pn        <= PROCESS_NOISE_RESET;
      mn        <= MEASUREMENT_NOISE_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end else if (accept) begin
        clr_cnt <= '0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_PROCESS_NOISE:     pn <= cfg_data;
          CFG_MEASUREMENT_NOISE: mn <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      idx  <= idx_in;
      meas <= {s_axis_tdata[O_LO-1:M_LO], 8'b0};
      off  <= s_axis_tdata[S_LO-1:O_LO];
      span <= s_axis_tdata[S_LO+ROW_BITS-1:S_LO];
    end
    unique case (state)
      ST_CHECK: begin
        x     <= rd_est;
        cov   <= rd_cov;
        xn    <= meas;
        first <= !rd_seen;
      end
      ST_FAR_DIV: begin
        if (div_rsp.done) begin
          far <= far_zero ? '0 : div_rsp.quotient;
        end
      end
      ST_FAR3: far2 <= prod[32:16];
      ST_QF:   far3 <= prod[32:16];
      ST_RF:   p <= p_sum[COV_BITS] ? '1 : p_sum[COV_BITS-1:0];
      ST_DEN:  denom <= {1'b0, p} + DIV_W'(prod[37:8]);
      ST_K_DIV: begin
        if (div_rsp.done) begin
          k <= (denom == '0) ? '0 : div_rsp.quotient;
        end
      end
      ST_P_MUL: xn <= x_ge ? x + x_step : x - x_step;
      default: ;
    endcase
    if (out_load) begin
      out_pos   <= xn;
      out_col   <= rsum[EST_W] ? '1 : rsum[EST_W-1:8];
      out_first <= first;
    end
  end

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({out_col, out_pos});
  assign m_axis_tuser  = out_first;

endmodule

/* src/skf_checker.sv */
// ----------------------------------------------------------------------------
// skf_checker: port-level checks of the scalar Kalman filter bank
// Watches the stream ports and is attached to the top level by bind.
// ----------------------------------------------------------------------------
module skf_checker #(
  parameter  int COORD_BITS = 12,
  localparam int EST_W      = COORD_BITS + 8,
  localparam int OUT_W      = ((2 * COORD_BITS + 8 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  logic [EST_W:0]        rsum;
  logic [COORD_BITS-1:0] col_exp;

  assign rsum    = {1'b0, m_axis_tdata[EST_W-1:0]} + (EST_W + 1)'(128);
  assign col_exp = rsum[EST_W] ? '1 : rsum[EST_W-1:8];

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on two consecutive cycles");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_axis_tready)
    else $error("input ready before the flag sweep after reset");

  a_rounded_column: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[EST_W+COORD_BITS-1:EST_W] == col_exp)
    else $error("rounded column does not match the filtered position");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed or dropped");

endmodule

bind scalar_kalman_filter_bank skf_checker #(
  .COORD_BITS (COORD_BITS)
) u_skf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
